[sv/btbw_pkg.sv]
// Package: shared types and constants for the BMP threshold blit writer.
`timescale 1ns / 1ps

package btbw_pkg;

    // Header byte positions within the BMP file
    localparam logic [11:0] HDR_OFFSET_POS = 12'd10;
    localparam logic [11:0] HDR_WIDTH_POS  = 12'd18;
    localparam logic [11:0] HDR_HEIGHT_POS = 12'd22;
    localparam logic [11:0] BYTE_COUNT_MAX = 12'd4095;

    // Lowest data offset that does not overlap the header
    localparam logic [7:0] MIN_OFFSET = 8'd23;

    // Gray level ceiling for the threshold
    localparam logic [3:0] MAX_LEVEL = 4'd14;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_X_POSITION = 2'd0;
    localparam logic [1:0] REG_Y_POSITION = 2'd1;
    localparam logic [1:0] REG_THRESHOLD  = 2'd2;

    // One framebuffer write word
    typedef struct packed {
        logic [8:0] pixel_address;
        logic [2:0] bit_index;
        logic       pixel_on;
        logic       rejected;
        logic       run_last;
    } result_t;

endpackage

[sv/bmp_threshold_blit_writer_core.sv]
// Top level: BMP 4 bpp to 1 bpp threshold blitter with APB register port.
`timescale 1ns / 1ps

// Takes a bottom-up 4 bpp BMP file one byte per input word and turns each
// pixel-data byte into two framebuffer bit writes (left pixel from the high
// nibble first). Header and skipped bytes (before the data offset, row
// padding, after the last row) give no output and are taken at one per cycle
// while in_ready is high. A pixel-data byte gives two output words, and the
// single output port delivers one word per cycle while out_ready is high.
// A two-entry result buffer sits between the decode logic and the output
// port; a new byte is taken when the buffer is empty or is being drained
// to empty in the same cycle. A failed clip check at byte 22 gives a single
// rejected word and the rest of the file is swallowed. After the byte
// flagged end_of_file all parse state returns to reset; registers keep their
// values. Registers: x_position at 0x0, y_position at 0x4, threshold at 0x8.
module bmp_threshold_blit_writer_core
    import btbw_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 84,
    parameter int SCREEN_HEIGHT = 48
)
(
    input  logic        clk,
    input  logic        rst_n,

    // Input byte stream
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  file_byte,
    input  logic        end_of_file,

    // Framebuffer write stream
    output logic        out_valid,
    input  logic        out_ready,
    output logic [8:0]  pixel_address,
    output logic [2:0]  bit_index,
    output logic        pixel_on,
    output logic        rejected,
    output logic        run_last,

    // Register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PAGES  = (SCREEN_HEIGHT + 7) / 8;
    localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;

    // Registers
    logic [7:0] x_position_reg;
    logic [7:0] y_position_reg;
    logic [3:0] threshold_reg;

    // Parse state
    logic [11:0]       byte_count_reg,   byte_count_next;
    logic [7:0]        image_width_reg,  image_width_next;
    logic [7:0]        image_height_reg, image_height_next;
    logic [7:0]        data_offset_reg,  data_offset_next;
    logic [2:0]        line_in_page_reg, line_in_page_next;
    logic [PAGE_W-1:0] page_row_reg,     page_row_next;
    logic [6:0]        pair_in_row_reg,  pair_in_row_next;
    logic [1:0]        pad_left_reg,     pad_left_next;
    logic [7:0]        rows_left_reg,    rows_left_next;
    logic              blocked_reg,      blocked_next;

    // Result buffer
    result_t    slot0_reg, slot1_reg;
    logic [1:0] count_reg;

    logic       in_fire, out_fire, cfg_we;
    logic [1:0] push_n;
    result_t    res0, res1;

    logic        fails;
    logic [9:0]  x_plus_w;
    logic [8:0]  y_plus_1;
    logic [3:0]  thr_sat;
    logic [15:0] base_sum;
    logic [6:0]  half;
    logic [7:0]  pair_inc;

    assign pready   = 1'b1;
    assign cfg_we   = psel && penable && pwrite;
    assign out_valid = (count_reg != 2'd0);
    assign out_fire = out_valid && out_ready;
    assign in_ready = (count_reg == 2'd0) || ((count_reg == 2'd1) && out_ready);
    assign in_fire  = in_valid && in_ready;

    assign pixel_address = slot0_reg.pixel_address;
    assign bit_index     = slot0_reg.bit_index;
    assign pixel_on      = slot0_reg.pixel_on;
    assign rejected      = slot0_reg.rejected;
    assign run_last      = slot0_reg.run_last;

    // Register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_position_reg <= '0;
            y_position_reg <= '0;
            threshold_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (paddr[3:2])
                REG_X_POSITION: x_position_reg <= pwdata[7:0];
                REG_Y_POSITION: y_position_reg <= pwdata[7:0];
                REG_THRESHOLD:  threshold_reg  <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // Register read
    always_comb
    begin
        unique case (paddr[3:2])
            REG_X_POSITION: prdata = {24'd0, x_position_reg};
            REG_Y_POSITION: prdata = {24'd0, y_position_reg};
            REG_THRESHOLD:  prdata = {28'd0, threshold_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // Clip checks, evaluated with the height byte on the input
    assign x_plus_w = {2'b00, x_position_reg} + {2'b00, image_width_reg};
    assign y_plus_1 = {1'b0, y_position_reg} + 9'd1;
    assign fails = (file_byte == 8'd0)
                || image_width_reg[0]
                || (x_plus_w > 10'(SCREEN_WIDTH))
                || (y_plus_1 < {1'b0, file_byte})
                || ({1'b0, y_position_reg} >= 9'(SCREEN_HEIGHT))
                || (data_offset_reg < MIN_OFFSET);

    // Pixel address and threshold
    assign thr_sat  = (threshold_reg > MAX_LEVEL) ? MAX_LEVEL : threshold_reg;
    assign base_sum = {8'd0, x_position_reg} + {8'd0, pair_in_row_reg, 1'b0}
                    + (16'(SCREEN_WIDTH) * 16'(page_row_reg));
    assign half     = image_width_reg[7:1];
    assign pair_inc = {1'b0, pair_in_row_reg} + 8'd1;

    // Byte decode and state update
    always_comb
    begin
        byte_count_next   = (byte_count_reg < BYTE_COUNT_MAX) ?
                            byte_count_reg + 12'd1 : byte_count_reg;
        image_width_next  = image_width_reg;
        image_height_next = image_height_reg;
        data_offset_next  = data_offset_reg;
        line_in_page_next = line_in_page_reg;
        page_row_next     = page_row_reg;
        pair_in_row_next  = pair_in_row_reg;
        pad_left_next     = pad_left_reg;
        rows_left_next    = rows_left_reg;
        blocked_next      = blocked_reg;
        push_n            = 2'd0;
        res0              = '0;
        res1              = '0;

        if (byte_count_reg == HDR_OFFSET_POS)
        begin
            data_offset_next = file_byte;
        end
        else if (byte_count_reg == HDR_WIDTH_POS)
        begin
            image_width_next = file_byte;
        end
        else if (byte_count_reg == HDR_HEIGHT_POS)
        begin
            image_height_next = file_byte;
            if (fails)
            begin
                blocked_next   = 1'b1;
                rows_left_next = '0;
                res0.rejected  = 1'b1;
                res0.run_last  = 1'b1;
                push_n         = 2'd1;
            end
            else
            begin
                line_in_page_next = y_position_reg[2:0];
                page_row_next     = PAGE_W'(y_position_reg >> 3);
                pair_in_row_next  = '0;
                pad_left_next     = '0;
                rows_left_next    = (image_width_reg == 8'd0) ? 8'd0 : file_byte;
            end
        end
        else if ((byte_count_reg > HDR_HEIGHT_POS) && !blocked_reg
                 && (rows_left_reg != 8'd0)
                 && (byte_count_reg >= {4'd0, data_offset_reg}))
        begin
            if (pad_left_reg != 2'd0)
            begin
                pad_left_next = pad_left_reg - 2'd1;
            end
            else
            begin
                res0.pixel_address = base_sum[8:0];
                res0.bit_index     = line_in_page_reg;
                res0.pixel_on      = (file_byte[7:4] > thr_sat);
                res1.pixel_address = base_sum[8:0] + 9'd1;
                res1.bit_index     = line_in_page_reg;
                res1.pixel_on      = (file_byte[3:0] > thr_sat);
                res1.run_last      = 1'b1;
                push_n             = 2'd2;
                pair_in_row_next   = pair_inc[6:0];
                // End of row: step one line up, skip the row padding
                if (pair_inc >= {1'b0, half})
                begin
                    pair_in_row_next = '0;
                    if (line_in_page_reg != 3'd0)
                    begin
                        line_in_page_next = line_in_page_reg - 3'd1;
                    end
                    else
                    begin
                        line_in_page_next = 3'd7;
                        page_row_next     = page_row_reg - PAGE_W'(1);
                    end
                    rows_left_next = rows_left_reg - 8'd1;
                    pad_left_next  = 2'd0 - half[1:0];
                end
            end
        end

        // Back to header mode after the last byte
        if (end_of_file)
        begin
            byte_count_next   = '0;
            image_width_next  = '0;
            image_height_next = '0;
            data_offset_next  = '0;
            line_in_page_next = '0;
            page_row_next     = '0;
            pair_in_row_next  = '0;
            pad_left_next     = '0;
            rows_left_next    = '0;
            blocked_next      = 1'b0;
        end
    end

    // Parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg   <= '0;
            image_width_reg  <= '0;
            image_height_reg <= '0;
            data_offset_reg  <= '0;
            line_in_page_reg <= '0;
            page_row_reg     <= '0;
            pair_in_row_reg  <= '0;
            pad_left_reg     <= '0;
            rows_left_reg    <= '0;
            blocked_reg      <= 1'b0;
        end
        else if (in_fire)
        begin
            byte_count_reg   <= byte_count_next;
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
            data_offset_reg  <= data_offset_next;
            line_in_page_reg <= line_in_page_next;
            page_row_reg     <= page_row_next;
            pair_in_row_reg  <= pair_in_row_next;
            pad_left_reg     <= pad_left_next;
            rows_left_reg    <= rows_left_next;
            blocked_reg      <= blocked_next;
        end
    end

    // Result buffer occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (in_fire)
        begin
            count_reg <= push_n;
        end
        else if (out_fire)
        begin
            count_reg <= count_reg - 2'd1;
        end
    end

    // Result buffer payload
    always_ff @(posedge clk)
    begin
        if (in_fire && (push_n != 2'd0))
        begin
            slot0_reg <= res0;
            slot1_reg <= res1;
        end
        else if (out_fire)
        begin
            slot0_reg <= slot1_reg;
        end
    end

    // Buffer never holds more than two words
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result buffer overfilled");

    // A full buffer blocks the input
    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2) |-> !in_ready)
        else $error("input taken with full buffer");

    // A pixel byte leaves both writes queued
    a_pair_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (push_n == 2'd2)) |=> (count_reg == 2'd2) && out_valid)
        else $error("pixel pair not queued");

    // A rejected word is alone and carries no pixel
    a_reject_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && rejected) |->
            (run_last && !pixel_on && (pixel_address == 9'd0) && (bit_index == 3'd0)))
        else $error("malformed rejected word");

    // Once rejected, the file gives no pixel writes
    a_blocked_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && blocked_reg) |-> (push_n == 2'd0))
        else $error("pixel write after rejection");

endmodule
